@@ rtl/phtt_pkg.sv @@
// Shared types and constants for the per-host threshold trigger table.
// Used by phtt_cell and per_host_threshold_trigger_table_top; depends on nothing.
package phtt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int ACTION_BITS   = 8;
	// Only the low action bits are stored and compared, never more than the field has.
	localparam int ACT_W         = (ACTION_BITS < 8) ? ACTION_BITS : 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	typedef enum logic [2:0] {
		ST_COUNTED  = 3'd0,
		ST_FIRED    = 3'd1,
		ST_FIRED_BL = 3'd2,
		ST_ACTIVE   = 3'd3,
		ST_NO_HOST  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_WINDOW    = 2'd1,
		CFG_BL_EN     = 2'd2,
		CFG_MONITOR   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  action_id;
		logic [63:0] address_key;
		logic        host_present;
		logic        needs_host;
		logic [31:0] event_time;
		logic        action_active;
		logic        on_blocklist;
	} evt_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] hit_count;
	} res_t;

	// Lookup context shared by all cells while one event walks the table.
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [63:0]      addr;
		logic [31:0]      now;
		logic [31:0]      window;
		logic [15:0]      thr;
		logic             bl;
	} scan_ctx_t;

	// Probe handed from one cell to the next.
	typedef struct packed {
		logic        vld;
		logic        found;
		logic        free_found;
		logic        fired;
		logic [15:0] hits;
	} probe_t;

endpackage

@@ rtl/phtt_cell.sv @@
// One table slot of the threshold trigger table: key, window start and hit count.
// Passes the lookup probe on to the next slot; depends on phtt_pkg.
module phtt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  phtt_pkg::scan_ctx_t ctx,
	input  phtt_pkg::probe_t    probe_in,
	input  logic                alloc,
	output phtt_pkg::probe_t    probe_out
);
	import phtt_pkg::*;

	logic             valid_q;
	logic             cand_q;
	logic [ACT_W-1:0] act_q;
	logic [63:0]      addr_q;
	logic [31:0]      start_q;
	logic [15:0]      hits_q;
	probe_t           probe_q;

	logic        match;
	logic        stale;
	logic        free_post;
	logic [15:0] hits_base;
	logic [15:0] hits_inc;
	logic        fire;
	probe_t      probe_next;

	assign match     = probe_in.vld && valid_q && !probe_in.found &&
	                   (act_q == ctx.act) && (addr_q == ctx.addr);
	assign stale     = (ctx.now - start_q) > ctx.window;
	assign hits_base = stale ? 16'd0 : hits_q;
	assign hits_inc  = (hits_base == 16'hFFFF) ? hits_base : hits_base + 16'd1;
	assign fire      = hits_inc >= ctx.thr;
	// Free once the trimming of this lookup is done; a matching slot is never free.
	assign free_post = !valid_q || (!match && stale);

	always_comb begin
		probe_next = probe_in;
		probe_next.free_found = probe_in.free_found | free_post;
		if (match) begin
			probe_next.found = 1'b1;
			if (ctx.bl) begin
				probe_next.hits = hits_q;
			end else begin
				probe_next.hits  = hits_inc;
				probe_next.fired = fire;
			end
		end
	end

	// The allocation at the end of a lookup never meets a probe in the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= 1'b0;
			probe_q <= '0;
		end else begin
			probe_q <= probe_next;
			if (alloc && cand_q) begin
				valid_q <= 1'b1;
				cand_q  <= 1'b0;
			end else if (probe_in.vld) begin
				cand_q <= free_post && !probe_in.free_found;
				if (match) begin
					if (ctx.bl || fire)
						valid_q <= 1'b0;
				end else if (valid_q && stale) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alloc && cand_q) begin
			act_q   <= ctx.act;
			addr_q  <= ctx.addr;
			start_q <= ctx.now;
			hits_q  <= 16'd1;
		end else if (match && !ctx.bl) begin
			hits_q <= hits_inc;
			if (stale)
				start_q <= ctx.now;
		end
	end

	assign probe_out = probe_q;

endmodule

@@ rtl/per_host_threshold_trigger_table_top.sv @@
// Top level of the per-host threshold trigger table: configuration registers,
// event control and the chain of table cells. Depends on phtt_pkg and phtt_cell.
//
// Usage:
// Events enter on the evt channel (evt_valid/evt_ready) and each one produces
// exactly one result on the res channel (res_valid/res_ready). Registers are
// written through cfg_we/cfg_addr/cfg_wdata; the user must write them only while
// no event is in flight, as the block itself does not enforce it. Events that
// need no table lookup (monitor mode, missing host, action already active) skip
// the scan and go straight to the done state. Events that look up the table send
// a probe down the row of TABLE_ENTRIES cells, one cell per cycle; the result is
// captured once the probe leaves the last cell, and the next event is taken once
// that result has moved on to the output register. One event is worked on at a time.
// The result sits in an output register, so a stalled receiver does not stop
// the next transaction from being accepted and looked up; only the hand-over of
// its result waits for the register to empty.
// Reset clears all table entries, restores the register defaults (threshold 1,
// window 600 s, blocklist off, monitor off) and empties the output register.
module per_host_threshold_trigger_table_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 evt_valid,
	output logic                                 evt_ready,
	input  phtt_pkg::evt_t                       evt,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output phtt_pkg::res_t                       res,
	input  logic                                 cfg_we,
	input  logic [phtt_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [phtt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import phtt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t    state_q;
	logic [15:0] thr_q;
	logic [31:0] window_q;
	logic        bl_en_q;
	logic        monitor_q;
	scan_ctx_t   ctx_q;
	logic        launch_q;
	res_t        pend_q;
	res_t        res_q;
	logic        res_valid_q;

	probe_t chain [TABLE_ENTRIES+1];
	probe_t tail;
	logic   accept;
	logic   needs_scan;
	res_t   fast_res;
	res_t   tail_res;
	logic   alloc;
	logic   thr_le1;

	assign evt_ready = (state_q == S_IDLE);
	assign accept    = evt_valid && evt_ready;
	assign thr_le1   = (thr_q <= 16'd1);
	assign tail      = chain[TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= 16'd1;
			window_q  <= 32'd600;
			bl_en_q   <= 1'b0;
			monitor_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_THRESHOLD: thr_q     <= cfg_wdata[15:0];
				CFG_WINDOW:    window_q  <= cfg_wdata[31:0];
				CFG_BL_EN:     bl_en_q   <= cfg_wdata[0];
				CFG_MONITOR:   monitor_q <= cfg_wdata[0];
				default:       thr_q     <= thr_q;
			endcase
		end
	end

	// Events decided without touching the table.
	always_comb begin
		needs_scan = 1'b0;
		fast_res   = '{status: ST_FULL, hit_count: 16'd0};
		if (monitor_q) begin
			fast_res = '{status: ST_FULL, hit_count: 16'd0};
		end else if (!evt.host_present) begin
			if (evt.needs_host)
				fast_res = '{status: ST_NO_HOST, hit_count: 16'd0};
			else
				fast_res = '{status: thr_le1 ? ST_FIRED : ST_COUNTED, hit_count: 16'd1};
		end else if (evt.action_active) begin
			fast_res = '{status: ST_ACTIVE, hit_count: 16'd0};
		end else begin
			needs_scan = 1'b1;
		end
	end

	// Result once the probe has passed every cell.
	always_comb begin
		alloc    = 1'b0;
		tail_res = '{status: ST_FULL, hit_count: 16'd0};
		if (ctx_q.bl) begin
			tail_res = '{status: ST_FIRED_BL, hit_count: tail.found ? tail.hits : 16'd0};
		end else if (tail.found) begin
			tail_res = '{status: tail.fired ? ST_FIRED : ST_COUNTED, hit_count: tail.hits};
		end else if (thr_le1) begin
			tail_res = '{status: ST_FIRED, hit_count: 16'd1};
		end else if (tail.free_found) begin
			tail_res = '{status: ST_COUNTED, hit_count: 16'd1};
			alloc    = (state_q == S_SCAN) && tail.vld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			launch_q <= accept && needs_scan;
			if (state_q == S_DONE && (!res_valid_q || res_ready))
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (needs_scan)
							state_q <= S_SCAN;
						else
							state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (tail.vld)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q       <= fast_res;
			ctx_q.act    <= evt.action_id[ACT_W-1:0];
			ctx_q.addr   <= evt.address_key;
			ctx_q.now    <= evt.event_time;
			ctx_q.window <= window_q;
			ctx_q.thr    <= thr_q;
			ctx_q.bl     <= bl_en_q && evt.on_blocklist && (thr_q != 16'd1);
		end
		if (state_q == S_SCAN && tail.vld)
			pend_q <= tail_res;
		if (state_q == S_DONE && (!res_valid_q || res_ready))
			res_q <= pend_q;
	end

	assign chain[0] = '{vld: launch_q, found: 1'b0, free_found: 1'b0, fired: 1'b0,
	                    hits: 16'd0};

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		phtt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctx      (ctx_q),
			.probe_in (chain[i]),
			.alloc    (alloc),
			.probe_out(chain[i+1])
		);
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ tb/tb_per_host_threshold_trigger_table_top.sv @@
// Testbench for per_host_threshold_trigger_table_top: directed cases and random traffic,
// checked against a predictor of the trigger table kept in the bench itself.
// Depends on phtt_pkg and the RTL of the block; stands alone otherwise.
module tb_per_host_threshold_trigger_table_top;
	import phtt_pkg::*;

	localparam int RAND_PHASES   = 13;
	localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
	localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_3210;
	localparam logic [63:0] KEY_C = 64'h8000_0000_0000_0001;

	logic                  clk;
	logic                  arst_n;
	logic                  evt_valid;
	logic                  evt_ready;
	evt_t                  evt;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Predictor copy of the register file and of the trigger table.
	logic [15:0]      cfg_thr     = 16'd1;
	logic [31:0]      cfg_win     = 32'd600;
	logic             cfg_bl_en   = 1'b0;
	logic             cfg_monitor = 1'b0;
	logic             table_valid [TABLE_ENTRIES] = '{default: 1'b0};
	logic [ACT_W-1:0] table_act   [TABLE_ENTRIES];
	logic [63:0]      table_addr  [TABLE_ENTRIES];
	logic [31:0]      table_start [TABLE_ENTRIES];
	logic [15:0]      table_hits  [TABLE_ENTRIES];

	res_t        pending_results[$];
	int          mismatch_count = 0;
	int          burst_left     = 0;
	logic [31:0] now_s          = 32'd0;
	logic [63:0] addr_pool [8];
	logic [7:0]  act_pool  [4];

	per_host_threshold_trigger_table_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_per_host_threshold_trigger_table_top NOT OK");
		$finish;
	end

	function automatic logic window_expired(input logic [31:0] now, input logic [31:0] start);
		logic [31:0] age;
		age = now - start;
		return age > cfg_win;
	endfunction

	// Works out the result of one accepted transaction and updates the table copy.
	function automatic res_t judge_event(input evt_t e);
		res_t             r;
		int               hit;
		int               slot_free;
		int               i;
		logic [ACT_W-1:0] act;
		logic [15:0]      cnt;
		hit = -1;
		slot_free = -1;
		act = e.action_id[ACT_W-1:0];
		r.hit_count = '0;
		if (cfg_monitor) begin
			r.status = ST_FULL;
			return r;
		end
		if (!e.host_present) begin
			if (e.needs_host) begin
				r.status = ST_NO_HOST;
			end else begin
				r.status = (cfg_thr <= 16'd1) ? ST_FIRED : ST_COUNTED;
				r.hit_count = 16'd1;
			end
			return r;
		end
		if (e.action_active) begin
			r.status = ST_ACTIVE;
			return r;
		end
		// The first matching entry survives; every other stale entry is dropped on the way.
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (table_valid[i]) begin
				if (hit < 0 && table_act[i] == act && table_addr[i] == e.address_key)
					hit = i;
				else if (window_expired(e.event_time, table_start[i]))
					table_valid[i] = 1'b0;
			end
		end
		for (i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!table_valid[i])
				slot_free = i;
		end
		if (cfg_bl_en && e.on_blocklist && cfg_thr != 16'd1) begin
			r.status = ST_FIRED_BL;
			if (hit >= 0) begin
				r.hit_count = table_hits[hit];
				table_valid[hit] = 1'b0;
			end
			return r;
		end
		if (hit >= 0) begin
			if (window_expired(e.event_time, table_start[hit])) begin
				table_start[hit] = e.event_time;
				table_hits[hit] = '0;
			end
			cnt = table_hits[hit];
			if (cnt != 16'hFFFF)
				cnt++;
			table_hits[hit] = cnt;
			r.hit_count = cnt;
			if (cnt >= cfg_thr) begin
				table_valid[hit] = 1'b0;
				r.status = ST_FIRED;
			end else begin
				r.status = ST_COUNTED;
			end
			return r;
		end
		if (cfg_thr <= 16'd1) begin
			r.status = ST_FIRED;
			r.hit_count = 16'd1;
		end else if (slot_free < 0) begin
			r.status = ST_FULL;
		end else begin
			table_valid[slot_free] = 1'b1;
			table_act[slot_free] = act;
			table_addr[slot_free] = e.address_key;
			table_start[slot_free] = e.event_time;
			table_hits[slot_free] = 16'd1;
			r.status = ST_COUNTED;
			r.hit_count = 16'd1;
		end
		return r;
	endfunction

	function automatic evt_t make_evt(input logic [7:0] act, input logic [63:0] addr,
			input logic host, input logic needs, input logic [31:0] t,
			input logic active, input logic listed);
		evt_t e;
		e.action_id = act;
		e.address_key = addr;
		e.host_present = host;
		e.needs_host = needs;
		e.event_time = t;
		e.action_active = active;
		e.on_blocklist = listed;
		return e;
	endfunction

	// Mostly repeats a few keys close together in time so windows fill and fire.
	function automatic evt_t random_event(input int span);
		evt_t e;
		case ($urandom_range(0, 39))
			0: now_s = now_s + cfg_win;
			1: now_s = now_s + cfg_win + 32'd1;
			2: now_s = $urandom;
			default: now_s = now_s + $urandom_range(0, 2);
		endcase
		e.action_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: act_pool[2'($urandom_range(0, 3))];
		e.address_key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
			: addr_pool[3'($urandom_range(0, span - 1))];
		e.host_present = $urandom_range(0, 99) >= 6;
		e.needs_host = 1'($urandom_range(0, 1));
		e.event_time = now_s;
		e.action_active = $urandom_range(0, 99) < 8;
		e.on_blocklist = $urandom_range(0, 99) < 12;
		return e;
	endfunction

	// Valid stays high across a burst; gaps of random length separate the bursts.
	task automatic send_event(input evt_t e);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				evt_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		evt = e;
		evt_valid = 1'b1;
		do @(posedge clk); while (!evt_ready);
		pending_results.push_back(judge_event(e));
		burst_left--;
	endtask

	task automatic drain_results();
		@(negedge clk);
		evt_valid = 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value;
		case (idx)
			CFG_THRESHOLD: cfg_thr = value[15:0];
			CFG_WINDOW:    cfg_win = value;
			CFG_BL_EN:     cfg_bl_en = value[0];
			CFG_MONITOR:   cfg_monitor = value[0];
			default:       cfg_thr = cfg_thr;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_event(make_evt(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_event(make_evt(8'h00, 64'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0));
		send_event(make_evt(8'h01, 64'h0, 1'b0, 1'b1, 32'h0, 1'b0, 1'b0));
		send_event(make_evt(8'h01, KEY_A, 1'b1, 1'b0, 32'h10, 1'b1, 1'b0));
		// Blocklist is off after reset, so a listed host counts normally.
		send_event(make_evt(8'h00, 64'h0, 1'b1, 1'b0, 32'h20, 1'b0, 1'b1));
	endtask

	task automatic test_window_counting();
		drain_results();
		write_reg(CFG_THRESHOLD, 32'd3);
		write_reg(CFG_WINDOW, 32'd10);
		// The window straddles the wrap of the seconds counter.
		send_event(make_evt(8'h05, KEY_A, 1'b1, 1'b0, 32'hFFFF_FFF8, 1'b0, 1'b0));
		send_event(make_evt(8'h05, KEY_A, 1'b1, 1'b0, 32'hFFFF_FFFC, 1'b0, 1'b0));
		send_event(make_evt(8'h05, KEY_A, 1'b1, 1'b0, 32'h0000_0002, 1'b0, 1'b0));
		send_event(make_evt(8'h05, KEY_A, 1'b1, 1'b0, 32'd100, 1'b0, 1'b0));
		send_event(make_evt(8'h05, KEY_A, 1'b1, 1'b0, 32'd111, 1'b0, 1'b0));
		send_event(make_evt(8'h06, KEY_A, 1'b1, 1'b0, 32'd111, 1'b0, 1'b0));
	endtask

	task automatic test_blocklist();
		drain_results();
		write_reg(CFG_BL_EN, 32'd1);
		send_event(make_evt(8'h05, KEY_A, 1'b1, 1'b0, 32'd112, 1'b0, 1'b1));
		send_event(make_evt(8'h05, KEY_A, 1'b1, 1'b0, 32'd113, 1'b0, 1'b0));
		send_event(make_evt(8'h07, KEY_C, 1'b1, 1'b0, 32'd113, 1'b0, 1'b1));
		drain_results();
		// A threshold of one overrides the blocklist path.
		write_reg(CFG_THRESHOLD, 32'd1);
		send_event(make_evt(8'h07, KEY_C, 1'b1, 1'b0, 32'd114, 1'b0, 1'b1));
	endtask

	task automatic test_threshold_edges();
		drain_results();
		write_reg(CFG_THRESHOLD, 32'd0);
		send_event(make_evt(8'h09, KEY_B, 1'b1, 1'b1, 32'd200, 1'b0, 1'b0));
		send_event(make_evt(8'h09, KEY_B, 1'b0, 1'b0, 32'd200, 1'b0, 1'b0));
		drain_results();
		write_reg(CFG_THRESHOLD, 32'd65535);
		write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
		send_event(make_evt(8'h0A, KEY_B, 1'b1, 1'b0, 32'd300, 1'b0, 1'b0));
		send_event(make_evt(8'h0A, KEY_B, 1'b1, 1'b0, 32'd5, 1'b0, 1'b0));
		send_event(make_evt(8'h0A, KEY_B, 1'b0, 1'b0, 32'd6, 1'b0, 1'b0));
	endtask

	task automatic test_monitor_mode();
		drain_results();
		write_reg(CFG_MONITOR, 32'd1);
		send_event(make_evt(8'h0A, KEY_B, 1'b1, 1'b0, 32'd7, 1'b0, 1'b1));
		send_event(make_evt(8'h0A, KEY_B, 1'b0, 1'b1, 32'd7, 1'b0, 1'b0));
		drain_results();
		write_reg(CFG_MONITOR, 32'd0);
	endtask

	task automatic test_random_traffic();
		logic [15:0] thr_tab [RAND_PHASES] = '{16'd2, 16'd3, 16'd1, 16'd0, 16'd4, 16'd65535,
			16'd2, 16'd5, 16'd3, 16'd2, 16'd2, 16'd2, 16'd3};
		logic [31:0] win_tab [RAND_PHASES] = '{32'd10, 32'd5, 32'd600, 32'd0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd1, 32'd20, 32'd0, 32'd30, 32'd8, 32'd8, 32'd40};
		logic        bl_tab  [RAND_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
			1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
		logic        mon_tab [RAND_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
		int          p;
		int          n;
		int          span;
		for (p = 0; p < RAND_PHASES; p++) begin
			drain_results();
			if (p == RAND_PHASES - 3) begin
				thr_tab[p] = 16'($urandom_range(0, 6));
				win_tab[p] = $urandom_range(0, 50);
				bl_tab[p] = 1'($urandom_range(0, 1));
			end
			write_reg(CFG_THRESHOLD, {16'd0, thr_tab[p]});
			write_reg(CFG_WINDOW, win_tab[p]);
			write_reg(CFG_BL_EN, {31'd0, bl_tab[p]});
			write_reg(CFG_MONITOR, {31'd0, mon_tab[p]});
			span = $urandom_range(2, 8);
			for (n = 0; n < (mon_tab[p] ? 60 : 155); n++)
				send_event(random_event(span));
		end
	endtask

	// The receiver alternates short ready runs, short stalls and long stall-free stretches.
	initial begin
		int run;
		logic level;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			case ($urandom_range(0, 7))
				0, 1: begin level = 1'b0; run = $urandom_range(1, 8); end
				2: begin level = 1'b1; run = $urandom_range(100, 300); end
				default: begin level = 1'b1; run = $urandom_range(1, 12); end
			endcase
			repeat (run) begin
				@(negedge clk);
				res_ready = level;
			end
		end
	end

	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: status %0d, hit_count %0d",
					res.status, res.hit_count);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (res.status !== exp_res.status) begin
					$error("status: expected %0d, actual %0d", exp_res.status, res.status);
					mismatch_count++;
				end
				if (res.hit_count !== exp_res.hit_count) begin
					$error("hit_count: expected %0d, actual %0d",
						exp_res.hit_count, res.hit_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		evt_valid = 1'b0;
		evt = '0;
		cfg_we = 1'b0;
		cfg_addr = CFG_THRESHOLD;
		cfg_wdata = '0;
		addr_pool[0] = 64'h0;
		addr_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		for (k = 2; k < 8; k++)
			addr_pool[k] = {$urandom, $urandom};
		act_pool[0] = 8'h00;
		act_pool[1] = 8'hFF;
		act_pool[2] = 8'($urandom_range(1, 254));
		act_pool[3] = 8'($urandom_range(1, 254));
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_window_counting();
		test_blocklist();
		test_threshold_edges();
		test_monitor_mode();
		test_random_traffic();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_per_host_threshold_trigger_table_top OK");
		else
			$display("tb_per_host_threshold_trigger_table_top NOT OK");
		$finish;
	end

endmodule
